// ===== src/svt_pkg.sv =====
// shared types and constants for the slot/value table
`timescale 1ns / 1ps

package svt_pkg;

  localparam int unsigned KEY_W = 31;
  localparam int unsigned VAL_W = 31;
  localparam int unsigned ST_W  = 2;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  // item kinds
  localparam logic KIND_CHANGE = 1'b0;
  localparam logic KIND_FIND   = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic start;     // latch a new item, restart the scan
    logic scan;      // issue the next table read, compare the last one
    logic update;    // rewrite the value of the matching entry
    logic insert;    // claim the next free entry or report full
    logic find_end;  // settle the find result
    logic load_out;  // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic kind;      // kind of the item in work
    logic match;     // compared entry matches this cycle
    logic scan_end;  // no read in flight and none left to issue
    logic out_busy;  // output register holds a beat not yet taken
  } sts_t;

endpackage

// ===== src/svt_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module svt_ram #(
  parameter int unsigned WIDTH = 62,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/svt_dpath.sv =====
// datapath: item registers, table scan, fill count, result and output registers
`timescale 1ns / 1ps

module svt_dpath #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  svt_pkg::cmd_t             cmd,
  output svt_pkg::sts_t             sts,
  input  logic                      kind,
  input  logic [svt_pkg::KEY_W-1:0] slot_key,
  input  logic [svt_pkg::VAL_W-1:0] number_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [svt_pkg::ST_W-1:0]  status,
  output logic [svt_pkg::KEY_W-1:0] found_key
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned DW = svt_pkg::KEY_W + svt_pkg::VAL_W;

  // item in work
  logic                      kind_r;
  logic [svt_pkg::KEY_W-1:0] key_r;
  logic [svt_pkg::VAL_W-1:0] val_r;

  // fill count: entries are claimed in order and never freed, so the
  // valid entries are always 0 .. count-1
  logic [CW-1:0] count;
  logic [CW-1:0] scan_idx;
  logic          cmp_valid;
  logic [AW-1:0] cmp_idx;

  logic                      hit;
  logic [svt_pkg::KEY_W-1:0] best;

  logic [svt_pkg::ST_W-1:0]  res_status;
  logic [svt_pkg::KEY_W-1:0] res_key;

  logic                      issue;
  logic                      full;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [DW-1:0]             ram_rdata;
  logic [svt_pkg::KEY_W-1:0] rd_key;
  logic [svt_pkg::VAL_W-1:0] rd_val;
  logic                      match;

  assign issue  = cmd.scan && (scan_idx < count);
  assign full   = (count == CW'(ENTRIES));
  assign rd_key = ram_rdata[svt_pkg::KEY_W-1:0];
  assign rd_val = ram_rdata[DW-1:svt_pkg::KEY_W];
  assign match  = cmp_valid &&
                  ((kind_r == svt_pkg::KIND_FIND) ? (rd_val == val_r) : (rd_key == key_r));

  assign ram_we    = cmd.update || (cmd.insert && !full);
  assign ram_waddr = cmd.update ? cmp_idx : count[AW-1:0];

  svt_ram #(
    .WIDTH (DW),
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({val_r, key_r}),
    .re    (issue),
    .raddr (scan_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.kind     = kind_r;
    sts.match    = match;
    sts.scan_end = !issue && !cmp_valid;
    sts.out_busy = out_valid && !out_ready;
  end

  // item latch and scan pointers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r <= kind;
      key_r  <= slot_key;
      val_r  <= number_value;
    end
    if (issue) begin
      cmp_idx <= scan_idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
      hit       <= 1'b0;
      best      <= '0;
    end else begin
      if (cmd.start) begin
        scan_idx  <= '0;
        cmp_valid <= 1'b0;
        hit       <= 1'b0;
        best      <= '0;
      end else begin
        if (issue) begin
          scan_idx <= scan_idx + 1'b1;
        end
        cmp_valid <= issue;
        if (cmd.scan && match && (kind_r == svt_pkg::KIND_FIND)) begin
          hit <= 1'b1;
          if (!hit || (rd_key < best)) begin
            best <= rd_key;
          end
        end
      end
      if (cmd.insert && !full) begin
        count <= count + 1'b1;
      end
    end
  end

  // result of the item
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_status <= svt_pkg::ST_OK;
      res_key    <= '0;
    end else if (cmd.insert) begin
      res_status <= full ? svt_pkg::ST_FULL : svt_pkg::ST_OK;
      res_key    <= '0;
    end else if (cmd.find_end) begin
      res_status <= hit ? svt_pkg::ST_OK : svt_pkg::ST_NOT_FOUND;
      res_key    <= hit ? best : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status    <= res_status;
      found_key <= res_key;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES))
    else $error("fill count beyond table size");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over a pending output beat");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.insert && !full) |=> (count == $past(count) + 1'b1))
    else $error("insert did not claim a new entry");

  a_update_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> (cmp_valid && match && (kind_r == svt_pkg::KIND_CHANGE)))
    else $error("value rewrite without a key match");
`endif

endmodule

// ===== src/svt_ctrl.sv =====
// controller: item sequencing over accept, table scan and result hand-off
`timescale 1ns / 1ps

module svt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output svt_pkg::cmd_t cmd,
  input  svt_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.match && (sts.kind == svt_pkg::KIND_CHANGE)) begin
          cmd.update = 1'b1;
          state_next = S_DONE;
        end else if (sts.scan_end) begin
          if (sts.kind == svt_pkg::KIND_FIND) begin
            cmd.find_end = 1'b1;
          end else begin
            cmd.insert = 1'b1;
          end
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.update && cmd.insert))
    else $error("rewrite and insert in the same cycle");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SCAN))
    else $error("accepted beat did not start a scan");

  a_single_end: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.update, cmd.insert, cmd.find_end}) <= 1)
    else $error("more than one scan end in one cycle");
`endif

endmodule

// ===== src/slot_value_table_min_index_lookup.sv =====
// top level: slot/value table with smallest-key lookup by value
`timescale 1ns / 1ps
// sequence: an item moves from accept to result beat through accept, one read per entry in
//   use, the last compare and the result load; a change that finds its key stops the scan early
// pacing: set by the scan through the single read port of the entry table; the next item
//   is taken only once the last result is in the output register, and may be taken while
//   that result beat waits on the output
// reset: rst clears the fill count, so the table reads as empty; stored keys and values
//   are not cleared, and entries at or above the fill count are never read

module slot_value_table_min_index_lookup #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input item stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // slot_key[30:0], number_value[61:31], zero[63:62]
  input  logic        s_axis_tuser,  // kind: 0 change, 1 find
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // status[1:0], found_key[32:2], zero[39:33]
);

  svt_pkg::cmd_t cmd;
  svt_pkg::sts_t sts;

  logic [svt_pkg::ST_W-1:0]  status;
  logic [svt_pkg::KEY_W-1:0] found_key;

  // sequencing: accept, scan, hand the result to the output register
  svt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // table memory, fill count, compare and min tracking, output register
  svt_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .kind         (s_axis_tuser),
    .slot_key     (s_axis_tdata[30:0]),
    .number_value (s_axis_tdata[61:31]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .status       (status),
    .found_key    (found_key)
  );

  // pack the result beat, pad bits are zero
  assign m_axis_tdata = {7'd0, found_key, status};

endmodule

// ===== sim/slot_value_table_min_index_lookup_test.sv =====
// testbench for the slot/value table with smallest-key lookup
`timescale 1ns / 1ps

module slot_value_table_min_index_lookup_test;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned PHASE_ITEMS = RANDOM_ITEMS / 4;
  // allows a full table scan plus margin, so this covers the tail
  localparam int unsigned DRAIN_CYCLES = TABLE_DEPTH + 16;
  localparam int unsigned STALL_LIMIT = 5000;

  typedef logic [svt_pkg::KEY_W-1:0] key_t;
  typedef logic [svt_pkg::VAL_W-1:0] val_t;

  localparam key_t KEY_MAX = {svt_pkg::KEY_W{1'b1}};
  localparam val_t VAL_MAX = {svt_pkg::VAL_W{1'b1}};

  typedef struct packed {
    logic [svt_pkg::ST_W-1:0] status;
    key_t                     found_key;
  } lookup_result_t;

  // one row of the directed table; a typed row carries its own expected result
  typedef struct {
    logic           kind;
    key_t           key;
    val_t           value;
    bit             typed;
    lookup_result_t result;
  } directed_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // slot_key[30:0], number_value[61:31], zero[63:62]
  logic        s_axis_tuser = 1'b0;  // kind: 0 change, 1 find
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;  // status[1:0], found_key[32:2], zero[39:33]

  slot_value_table_min_index_lookup #(
    .ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // shadow copy of the table contents
  logic tbl_valid [TABLE_DEPTH];
  key_t tbl_key   [TABLE_DEPTH];
  val_t tbl_value [TABLE_DEPTH];

  lookup_result_t pending_results[$];
  directed_row_t  directed_rows[$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned writes_ok = 0;
  int unsigned writes_full = 0;
  int unsigned finds_hit = 0;
  int unsigned finds_miss = 0;
  int unsigned multi_hits = 0;

  lookup_result_t mon_got;
  lookup_result_t mon_want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // apply one item to the shadow table and return the result it should produce
  function automatic lookup_result_t table_apply(input logic kind, input key_t key,
                                                 input val_t value);
    lookup_result_t res;
    int free_idx;
    int hits;
    res.status = svt_pkg::ST_OK;
    res.found_key = '0;
    free_idx = -1;
    hits = 0;
    if (kind == svt_pkg::KIND_CHANGE) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (tbl_valid[i] && tbl_key[i] == key) begin
          tbl_value[i] = value;
          return res;
        end
        if (!tbl_valid[i] && free_idx < 0) free_idx = i;
      end
      if (free_idx < 0) begin
        res.status = svt_pkg::ST_FULL;
      end else begin
        tbl_valid[free_idx] = 1'b1;
        tbl_key[free_idx] = key;
        tbl_value[free_idx] = value;
      end
    end else begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (tbl_valid[i] && tbl_value[i] == value) begin
          if (hits == 0 || tbl_key[i] < res.found_key) res.found_key = tbl_key[i];
          hits++;
        end
      end
      if (hits == 0) res.status = svt_pkg::ST_NOT_FOUND;
      if (hits > 1) multi_hits++;
    end
    return res;
  endfunction

  task automatic add_row(input logic kind, input key_t key, input val_t value, input bit typed,
                         input logic [svt_pkg::ST_W-1:0] status, input key_t found_key);
    directed_row_t row;
    row.kind = kind;
    row.key = key;
    row.value = value;
    row.typed = typed;
    row.result.status = status;
    row.result.found_key = found_key;
    directed_rows.push_back(row);
  endtask

  // drive one beat at the falling edge and hold it until the block takes it
  task automatic send_item(input logic kind, input key_t key, input val_t value,
                           input bit typed, input lookup_result_t typed_result);
    lookup_result_t predicted;
    @(negedge clk);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, value, key};
    s_axis_tuser <= kind;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    predicted = table_apply(kind, key, value);
    if (kind == svt_pkg::KIND_CHANGE) begin
      if (predicted.status == svt_pkg::ST_FULL) writes_full++;
      else writes_ok++;
    end else begin
      if (predicted.status == svt_pkg::ST_OK) finds_hit++;
      else finds_miss++;
    end
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic note_failure(input string what, input lookup_result_t want,
                              input lookup_result_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s: expected status %0d key %h, got status %0d key %h", $realtime, what,
               want.status, want.found_key, got.status, got.found_key);
  endtask

  // receiver side: random stalls set per phase
  always @(negedge clk) begin
    m_axis_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  // result checker: every result beat is matched to the oldest pending expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      mon_got.status = m_axis_tdata[1:0];
      mon_got.found_key = m_axis_tdata[32:2];
      if (pending_results.size() == 0) begin
        note_failure("result beat with nothing pending", '0, mon_got);
      end else begin
        mon_want = pending_results.pop_front();
        if (mon_got.status !== mon_want.status || mon_got.found_key !== mon_want.found_key)
          note_failure("result mismatch", mon_want, mon_got);
      end
    end
  end

  // watchdog: too long without any beat on either side means the block hung
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic           kind;
    key_t           key;
    val_t           value;
    int unsigned    pick;
    int unsigned    idx;
    lookup_result_t no_result;
    val_t           value_pool [4];

    no_result = '0;
    value_pool[0] = 31'd7;
    value_pool[1] = 31'h5555_5555;
    value_pool[2] = '0;
    value_pool[3] = VAL_MAX;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_value[i] = '0;
    end

    // lookups on an empty table, extremes, replace in place
    add_row(svt_pkg::KIND_FIND,   KEY_MAX,       '0,            1'b1, svt_pkg::ST_NOT_FOUND, '0);
    add_row(svt_pkg::KIND_CHANGE, KEY_MAX,       VAL_MAX,       1'b1, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_CHANGE, '0,            VAL_MAX,       1'b1, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_FIND,   31'h2AAA_AAAA, VAL_MAX,       1'b1, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_CHANGE, '0,            '0,            1'b1, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_FIND,   '0,            VAL_MAX,       1'b1, svt_pkg::ST_OK, KEY_MAX);
    add_row(svt_pkg::KIND_FIND,   KEY_MAX,       '0,            1'b1, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_FIND,   31'h0000_1234, 31'h0000_1234, 1'b1, svt_pkg::ST_NOT_FOUND, '0);
    // fill the rest of the table; values repeat so lookups see several matches
    add_row(svt_pkg::KIND_CHANGE, 31'h5555_5555, 31'd7,         1'b0, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_CHANGE, 31'h2AAA_AAAA, 31'h5555_5555, 1'b0, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_CHANGE, 31'h4000_0000, 31'd7,         1'b0, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_CHANGE, 31'h0000_0001, 31'h5555_5555, 1'b0, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_CHANGE, 31'h1234_5678, 31'd7,         1'b0, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_CHANGE, 31'h00AB_CDEF, 31'h2AAA_AAAA, 1'b0, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_CHANGE, 31'h7FFF_FFFE, 31'd7,         1'b0, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_CHANGE, 31'h3C3C_3C3C, 31'h0000_0001, 1'b0, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_CHANGE, 31'h0000_0010, 31'h2AAA_AAAA, 1'b0, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_CHANGE, 31'h600D_F00D, 31'd7,         1'b0, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_CHANGE, 31'h0F0F_0F0F, VAL_MAX,       1'b0, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_CHANGE, 31'h7000_0001, 31'h5555_5555, 1'b0, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_CHANGE, 31'h0000_0002, '0,            1'b0, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_CHANGE, 31'h5A5A_5A5A, 31'd7,         1'b0, svt_pkg::ST_OK, '0);
    // table now full: a new key is dropped, an existing key still updates
    add_row(svt_pkg::KIND_CHANGE, 31'h1357_9BDF, 31'd3,         1'b1, svt_pkg::ST_FULL, '0);
    add_row(svt_pkg::KIND_FIND,   31'h1357_9BDF, 31'd3,         1'b0, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_FIND,   '0,            31'd7,         1'b0, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_CHANGE, 31'h4000_0000, VAL_MAX,       1'b1, svt_pkg::ST_OK, '0);
    add_row(svt_pkg::KIND_FIND,   KEY_MAX,       VAL_MAX,       1'b0, svt_pkg::ST_OK, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].kind, directed_rows[i].key, directed_rows[i].value,
                directed_rows[i].typed, directed_rows[i].result);

    for (int phase = 0; phase < 4; phase++) begin
      // sender drops valid and holds off until the block has drained everything
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 86; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 86; end
        default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = 1'($urandom_range(1));
        pick = $urandom_range(99);
        idx = $urandom_range(TABLE_DEPTH - 1);
        // change keys mostly hit stored entries; new random keys are dropped as table full
        if (kind == svt_pkg::KIND_FIND) key = key_t'($urandom);
        else if (pick < 60 && tbl_valid[idx]) key = tbl_key[idx];
        else if (pick < 75) key = (pick[0]) ? KEY_MAX : '0;
        else key = key_t'($urandom);
        pick = $urandom_range(99);
        idx = $urandom_range(TABLE_DEPTH - 1);
        if (kind == svt_pkg::KIND_FIND && pick < 55 && tbl_valid[idx]) value = tbl_value[idx];
        else if (pick < 75) value = value_pool[$urandom_range(3)];
        else if (pick < 88) value = val_t'($urandom_range(15));
        else value = val_t'($urandom);
        send_item(kind, key, value, 1'b0, no_result);
      end
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      fail_count++;
      $display("%0d expected results never arrived", pending_results.size());
    end

    $display("covered %0d writes (%0d dropped on a full table) and %0d lookups",
             writes_ok + writes_full, writes_full, finds_hit + finds_miss);
    $display("lookups: %0d hits (%0d with several matching entries), %0d misses; %0d failures",
             finds_hit, multi_hits, finds_miss, fail_count);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
src/svt_pkg.sv
src/svt_ram.sv
src/svt_dpath.sv
src/svt_ctrl.sv
src/slot_value_table_min_index_lookup.sv
sim/slot_value_table_min_index_lookup_test.sv
